// File: sv/wrs_pkg.sv
`timescale 1ns / 1ps
package wrs_pkg;

  localparam int NUM_CH  = 8;
  localparam int IDX_W   = 3;
  localparam int CNT_W   = 4;
  localparam int W_W     = 16;
  localparam int FRAC_W  = 8;
  localparam int BASE_W  = 24;
  localparam int TIX_W   = BASE_W - FRAC_W;
  localparam int ACC_W   = 19;
  localparam int MULT_W  = 24;
  localparam int PROD_W  = 40;
  localparam int SUM_W   = 42;

  localparam logic [CNT_W-1:0] CHILD_COUNT_RST = CNT_W'(NUM_CH);

  // configuration register indexes
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam logic MODE_INDEP   = 1'b0;
  localparam logic MODE_SHUFFLE = 1'b1;

  localparam logic signed [SUM_W-1:0] BASE_MAX = SUM_W'(64'sd8388607);
  localparam logic signed [SUM_W-1:0] BASE_MIN = -SUM_W'(64'sd8388608);
  localparam logic signed [BASE_W:0]  CW_ONE   = (BASE_W+1)'(1 << FRAC_W);

  typedef struct packed {
    logic [W_W-1:0] weight_0;
    logic [W_W-1:0] weight_1;
    logic [W_W-1:0] weight_2;
    logic [W_W-1:0] weight_3;
    logic [W_W-1:0] weight_4;
    logic [W_W-1:0] weight_5;
    logic [W_W-1:0] weight_6;
    logic [W_W-1:0] weight_7;
    logic [7:0]     active_mask;
    logic [15:0]    random_fraction;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] picked_index;
    logic             none_picked;
  } out_word_t;

  typedef struct packed {
    logic              done;
    logic [MULT_W-1:0] quot;
    logic              rem_nz;
  } div_res_t;

  function automatic logic [BASE_W-1:0] sat_base(input logic signed [SUM_W-1:0] v);
    logic [BASE_W-1:0] r;
    if (v > BASE_MAX) r = BASE_MAX[BASE_W-1:0];
    else if (v < BASE_MIN) r = BASE_MIN[BASE_W-1:0];
    else r = v[BASE_W-1:0];
    return r;
  endfunction

  // weight plus base, signed
  function automatic logic signed [BASE_W:0] cw_of(input logic [W_W-1:0] w,
                                                  input logic [BASE_W-1:0] b);
    return $signed({{(BASE_W+1-W_W){1'b0}}, w}) + $signed({b[BASE_W-1], b});
  endfunction

  function automatic logic [TIX_W-1:0] tix_of(input logic signed [BASE_W:0] cw);
    logic [TIX_W-1:0] t;
    if (cw >= CW_ONE) t = cw[BASE_W-1:FRAC_W];
    else t = '0;
    return t;
  endfunction

endpackage

// File: sv/wrs_div.sv
`timescale 1ns / 1ps
module wrs_div
  import wrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MULT_W-1:0] num,
  input  logic [W_W-1:0]    den,
  output div_res_t          res
);

  localparam int CNT_BITS = $clog2(MULT_W + 1);

  logic [MULT_W-1:0]   quot_r;
  logic [W_W-1:0]      rem_r;
  logic [W_W-1:0]      den_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [W_W:0]        trial;
  logic                take;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_r, quot_r[MULT_W-1]};
  assign take  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_BITS'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(MULT_W);
        quot_r <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        cnt_r  <= cnt_r - CNT_BITS'(1);
        busy_r <= cnt_r != CNT_BITS'(1);
        quot_r <= {quot_r[MULT_W-2:0], take};
        rem_r  <= take ? W_W'(trial - {1'b0, den_r}) : trial[W_W-1:0];
      end
    end
  end

  assign res.done   = done_r;
  assign res.quot   = quot_r;
  assign res.rem_nz = rem_r != '0;

endmodule

// File: sv/weighted_random_child_select.sv
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_data (in_word_t)
// out     | output    | out_valid / out_ready| out_data (out_word_t)
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// independent mode: sum pass, one multiply, scan pass, output for each word
// shuffled mode: a divide per child below one ticket (shared divider),
// plus a deck refill pass (one multiplier, multiply then update per child)
// reset sets independent mode, child count 8, all child bases 0, out_valid low
// a word is accepted only in idle; a finished word waits in the output register
module weighted_random_child_select
  import wrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_MUL, S_SCAN, S_TCNT, S_DIV, S_RAISE, S_OUT
  } state_t;

  state_t             state_r;
  logic               mode_cfg_r;
  logic [CNT_W-1:0]   count_cfg_r;

  logic               mode_r;
  logic [CNT_W-1:0]   n_r;
  logic [W_W-1:0]     w_r [NUM_CH];
  logic [NUM_CH-1:0]  mask_r;
  logic [15:0]        frac_r;
  logic [BASE_W-1:0]  base_r [NUM_CH];
  logic [IDX_W-1:0]   idx_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   cum_r;
  logic [PROD_W-1:0]  prod_r;
  logic [MULT_W-1:0]  mult_r;
  logic               have_mult_r;
  logic               any_elig_r;
  logic               phase_r;
  logic               out_valid_r;
  out_word_t          out_data_r;
  logic [IDX_W-1:0]   pick_r;
  logic               none_r;

  logic [W_W-1:0]     cur_w;
  logic [BASE_W-1:0]  cur_b;
  logic               in_use, cur_act, cur_elig, last;
  logic signed [BASE_W:0] cw, cw_raised, n_diff;
  logic               cw_ge;
  logic [TIX_W-1:0]   cur_tix;
  logic [ACC_W-1:0]   tcnt_acc;
  logic               step_ok;
  logic [ACC_W-1:0]   step_val, cum_new;
  logic               hit;
  logic [15:0]        mul_a;
  logic [MULT_W-1:0]  mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [BASE_W-1:0]  raised_b, dropped_b;
  logic [MULT_W-1:0]  div_q;
  logic               div_start;
  div_res_t           div_res;

  assign cur_w   = w_r[idx_r];
  assign cur_b   = base_r[idx_r];
  assign in_use  = {1'b0, idx_r} < n_r;
  assign cur_act = mask_r[idx_r] && in_use;
  assign cur_elig = cur_act && (cur_w != '0);
  assign last    = idx_r == IDX_W'(NUM_CH - 1);
  assign cw      = cw_of(cur_w, cur_b);
  assign cw_ge   = cw >= CW_ONE;
  assign cur_tix = tix_of(cw);
  assign tcnt_acc = acc_r + ((cur_elig && cw_ge) ? ACC_W'(cur_tix) : '0);
  assign n_diff  = CW_ONE - cw;

  assign div_start = (state_r == S_TCNT) && cur_elig && !cw_ge;
  assign div_q     = div_res.quot + MULT_W'(div_res.rem_nz);

  // scan step: weights in independent mode, tickets in shuffled mode
  always_comb begin
    if (mode_r == MODE_SHUFFLE) begin
      step_ok  = cur_elig && (cur_tix != '0);
      step_val = ACC_W'(cur_tix);
    end else begin
      step_ok  = cur_elig;
      step_val = ACC_W'(cur_w);
    end
  end
  assign cum_new = cum_r + step_val;
  assign hit = step_ok && (prod_r <= {{(PROD_W-ACC_W-16){1'b0}}, cum_new, 16'b0});

  // shared multiplier operands
  always_comb begin
    if (state_r == S_RAISE) begin
      mul_a = cur_w;
      mul_b = mult_r;
    end else begin
      mul_a = frac_r;
      mul_b = MULT_W'(acc_r);
    end
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign raised_b = sat_base($signed({{(SUM_W-BASE_W){cur_b[BASE_W-1]}}, cur_b})
                             + $signed({{(SUM_W-PROD_W){1'b0}}, prod_r}));
  assign dropped_b = sat_base($signed({{(SUM_W-BASE_W){cur_b[BASE_W-1]}}, cur_b})
                              - SUM_W'(CW_ONE));
  assign cw_raised = cw_of(cur_w, raised_b);

  wrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (n_diff[MULT_W-1:0]),
    .den   (cur_w),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_cfg_r  <= MODE_INDEP;
      count_cfg_r <= CHILD_COUNT_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) base_r[i] <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MODE:  mode_cfg_r  <= cfg_data[0];
          CFG_COUNT: count_cfg_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            w_r[0] <= in_data.weight_0;
            w_r[1] <= in_data.weight_1;
            w_r[2] <= in_data.weight_2;
            w_r[3] <= in_data.weight_3;
            w_r[4] <= in_data.weight_4;
            w_r[5] <= in_data.weight_5;
            w_r[6] <= in_data.weight_6;
            w_r[7] <= in_data.weight_7;
            mask_r <= in_data.active_mask;
            frac_r <= in_data.random_fraction;
            mode_r <= mode_cfg_r;
            n_r    <= (count_cfg_r > CNT_W'(NUM_CH)) ? CNT_W'(NUM_CH) : count_cfg_r;
            idx_r  <= '0;
            acc_r  <= '0;
            cum_r  <= '0;
            have_mult_r <= 1'b0;
            any_elig_r  <= 1'b0;
            phase_r     <= 1'b0;
            state_r <= (mode_cfg_r == MODE_SHUFFLE) ? S_TCNT : S_SUM;
          end
        end
        S_SUM: begin
          if (cur_act) acc_r <= acc_r + ACC_W'(cur_w);
          idx_r <= idx_r + IDX_W'(1);
          if (last) state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= mul_p;
          idx_r  <= '0;
          cum_r  <= '0;
          if (acc_r == '0) begin
            pick_r  <= '0;
            none_r  <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // skipped children do not move the position
          if (step_ok) cum_r <= cum_new;
          idx_r <= idx_r + IDX_W'(1);
          if (hit) begin
            pick_r  <= idx_r;
            none_r  <= 1'b0;
            if (mode_r == MODE_SHUFFLE) base_r[idx_r] <= dropped_b;
            state_r <= S_OUT;
          end else if (last) begin
            pick_r  <= '0;
            none_r  <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_TCNT, S_DIV: begin
          if (state_r == S_TCNT && cur_elig) any_elig_r <= 1'b1;
          if (div_start) begin
            state_r <= S_DIV;
          end else if (state_r == S_TCNT || div_res.done) begin
            if (div_res.done && (!have_mult_r || div_q < mult_r)) mult_r <= div_q;
            if (div_res.done) have_mult_r <= 1'b1;
            acc_r <= tcnt_acc;
            idx_r <= idx_r + IDX_W'(1);
            if (last) begin
              if (tcnt_acc != '0) begin
                state_r <= S_MUL;
              end else if (!(any_elig_r || cur_elig)) begin
                pick_r  <= '0;
                none_r  <= 1'b1;
                state_r <= S_OUT;
              end else begin
                state_r <= S_RAISE;
                phase_r <= 1'b0;
              end
            end else begin
              state_r <= S_TCNT;
            end
          end
        end
        S_RAISE: begin
          if (!phase_r) begin
            prod_r  <= mul_p;
            phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
            if (in_use && cur_w != '0) base_r[idx_r] <= raised_b;
            // recount against the raised base
            if (cur_elig) acc_r <= acc_r + ACC_W'(tix_of(cw_raised));
            idx_r <= idx_r + IDX_W'(1);
            if (last) state_r <= S_MUL;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r.picked_index <= pick_r;
            out_data_r.none_picked  <= none_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word but stayed ready");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide step");

  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && (!out_valid_r || out_ready) |=> in_ready && out_valid)
    else $error("result not posted on leaving the output step");
`endif

endmodule
